FILE: sv/msp_pkg.sv
// Shared types, constants and the misspelling table for the word spotter.
`timescale 1ns / 1ps
`default_nettype none
package msp_pkg;

	localparam int DEF_PATTERN_COUNT   = 15;
	localparam int DEF_MAX_PATTERN_LEN = 11;
	localparam int ROM_SIZE            = 15;
	localparam int ROM_TEXT_LEN        = 11;

	localparam int CHAR_W   = 16;
	localparam int POS_W    = 32;
	localparam int START_W  = 31;
	localparam int LENGTH_W = 4;
	localparam int COUNT_W  = 16;

	localparam logic [COUNT_W-1:0] REPORT_LIMIT_RESET = 16'd64;

	// Lowercase patterns, right-justified; first letter sits highest.
	localparam logic [8*ROM_TEXT_LEN-1:0] PATTERN_TEXT [ROM_SIZE] = '{
		88'("acheive"), 88'("adress"), 88'("arguement"), 88'("becuase"),
		88'("definately"), 88'("embarass"), 88'("goverment"),
		88'("independant"), 88'("occured"), 88'("recieve"), 88'("seperate"),
		88'("teh"), 88'("thier"), 88'("untill"), 88'("wierd")
	};

	localparam logic [LENGTH_W-1:0] PATTERN_LEN [ROM_SIZE] = '{
		4'd7, 4'd6, 4'd9, 4'd7, 4'd10, 4'd8, 4'd9, 4'd11, 4'd7, 4'd7, 4'd8,
		4'd3, 4'd5, 4'd6, 4'd5
	};

	typedef struct packed {
		logic       letter;
		logic [7:0] folded;
	} char_class_t;

	typedef struct packed {
		logic                opening;
		logic                close;
		logic                matched;
		logic [LENGTH_W-1:0] match_len;
	} token_info_t;

	// Letter idx of pattern p; zero past the pattern's end.
	function automatic logic [7:0] pattern_char(input int p, input int idx);
		int                      len;
		logic [8*ROM_TEXT_LEN-1:0] shifted;
		len = int'(PATTERN_LEN[p]);
		shifted = '0;
		if (idx < len) begin
			shifted = PATTERN_TEXT[p] >> (8 * (len - 1 - idx));
		end
		return shifted[7:0];
	endfunction

endpackage
`default_nettype wire

FILE: sv/msp_classify.sv
// Letter detection and ASCII case folding of one code unit.
`timescale 1ns / 1ps
`default_nettype none
module msp_classify (
	input  wire logic [msp_pkg::CHAR_W-1:0] char_code,
	output msp_pkg::char_class_t            cls
);

	logic upper;
	logic lower;

	always_comb begin
		upper = char_code inside {[16'h0041:16'h005A]};
		lower = char_code inside {[16'h0061:16'h007A]};
		cls.letter = upper | lower;
		cls.folded = upper ? (char_code[7:0] + 8'd32) : char_code[7:0];
	end

endmodule
`default_nettype wire

FILE: sv/msp_pattern_unit.sv
// Token tracker: letter count, per-pattern alive mask and whole-token match.
`timescale 1ns / 1ps
`default_nettype none
module msp_pattern_unit #(
	parameter int PATTERN_COUNT   = msp_pkg::DEF_PATTERN_COUNT,
	parameter int MAX_PATTERN_LEN = msp_pkg::DEF_MAX_PATTERN_LEN
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 fire,
	input  wire logic                 eot,
	input  wire msp_pkg::char_class_t cls,
	output msp_pkg::token_info_t      info
);

	localparam int ACTIVE = (PATTERN_COUNT < msp_pkg::ROM_SIZE) ?
		PATTERN_COUNT : msp_pkg::ROM_SIZE;
	localparam int LW = $clog2(MAX_PATTERN_LEN + 2);
	localparam logic [LW-1:0] SAT = LW'(MAX_PATTERN_LEN + 1);

	logic              inside_q;
	logic [LW-1:0]     letters_q;
	logic [ACTIVE-1:0] alive_q;

	logic [LW-1:0]     idx;
	logic [LW-1:0]     letters_n;
	logic [ACTIVE-1:0] base_alive;
	logic [ACTIVE-1:0] alive_n;
	logic [ACTIVE-1:0] hit;
	logic              open_n;

	always_comb begin
		idx        = inside_q ? letters_q : '0;
		base_alive = inside_q ? alive_q : '1;
		alive_n    = alive_q;
		letters_n  = letters_q;
		if (cls.letter) begin
			for (int p = 0; p < ACTIVE; p++) begin
				alive_n[p] = base_alive[p] &&
					(int'(idx) < int'(msp_pkg::PATTERN_LEN[p])) &&
					(msp_pkg::pattern_char(p, int'(idx)) == cls.folded);
			end
			letters_n = (idx < SAT) ? idx + LW'(1) : idx;
		end
		for (int p = 0; p < ACTIVE; p++) begin
			hit[p] = alive_n[p] && (int'(letters_n) == int'(msp_pkg::PATTERN_LEN[p]));
		end
		open_n         = inside_q | cls.letter;
		info.opening   = cls.letter & ~inside_q;
		info.close     = open_n & (~cls.letter | eot);
		info.matched   = info.close && (letters_n != '0) &&
			(int'(letters_n) <= MAX_PATTERN_LEN) && (|hit);
		info.match_len = msp_pkg::LENGTH_W'(letters_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q  <= 1'b0;
			letters_q <= '0;
			alive_q   <= '1;
		end else if (fire) begin
			if (info.close || eot) begin
				inside_q  <= 1'b0;
				letters_q <= '0;
				alive_q   <= '1;
			end else if (cls.letter) begin
				inside_q  <= 1'b1;
				letters_q <= letters_n;
				alive_q   <= alive_n;
			end
		end
	end

endmodule
`default_nettype wire

FILE: sv/misspelled_word_spotter.sv
// Top level of the whole-word misspelling spotter.
// Scans a text one 16-bit code unit per item and reports every ASCII letter
// token that equals, ignoring case, one of the built-in misspellings. An item
// is held in the input register, then the token logic updates the alive mask
// and counters and loads the report register: one item per cycle sustained
// while no waiting report is held back by m_tready; a report passes the input
// register and then the report register. The token state update is a feedback
// loop, as are the position and report counters. A report (token start and
// length) leaves on the item that closes the token: the first separator or a
// final letter with tlast. At most cfg_data reports per text are made; tokens
// starting past 2^31-1 are not reported. tlast on the input ends the text and
// clears position, count and token state. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module misspelled_word_spotter #(
	parameter int PATTERN_COUNT   = msp_pkg::DEF_PATTERN_COUNT,
	parameter int MAX_PATTERN_LEN = msp_pkg::DEF_MAX_PATTERN_LEN
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [15:0] char_code
	input  wire logic        s_tlast,   // end_of_text
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // [30:0] range_start, [34:31] range_length
	output logic             m_tlast,   // last_of_text
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data   // report_limit
);

	logic                          valid_s1;
	logic [msp_pkg::CHAR_W-1:0]    char_s1;
	logic                          eot_s1;
	logic                          advance;

	logic [msp_pkg::COUNT_W-1:0]   limit_q;
	logic [msp_pkg::POS_W-1:0]     pos_q;
	logic [msp_pkg::POS_W-1:0]     begin_q;
	logic [msp_pkg::COUNT_W-1:0]   reports_q;

	logic                          out_valid_q;
	logic [msp_pkg::START_W-1:0]   start_q;
	logic [msp_pkg::LENGTH_W-1:0]  len_q;
	logic                          last_q;

	msp_pkg::char_class_t          cls;
	msp_pkg::token_info_t          info;
	logic [msp_pkg::POS_W-1:0]     begin_eff;
	logic                          report;

	assign advance   = valid_s1 & (~out_valid_q | m_tready);
	assign s_tready  = ~valid_s1 | advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
			eot_s1  <= s_tlast;
		end
	end

	msp_classify u_classify (
		.char_code (char_s1),
		.cls       (cls)
	);

	msp_pattern_unit #(
		.PATTERN_COUNT   (PATTERN_COUNT),
		.MAX_PATTERN_LEN (MAX_PATTERN_LEN)
	) u_pattern (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.eot    (eot_s1),
		.cls    (cls),
		.info   (info)
	);

	assign begin_eff = info.opening ? pos_q : begin_q;
	assign report    = info.matched && !begin_eff[msp_pkg::POS_W-1] &&
		(reports_q < limit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q   <= msp_pkg::REPORT_LIMIT_RESET;
			pos_q     <= '0;
			begin_q   <= '0;
			reports_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
			if (advance) begin
				if (eot_s1) begin
					pos_q     <= '0;
					begin_q   <= '0;
					reports_q <= '0;
				end else begin
					if (pos_q != '1) begin
						pos_q <= pos_q + 1'b1;
					end
					begin_q <= begin_eff;
					if (report) begin
						reports_q <= reports_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= report;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && report) begin
			start_q <= begin_eff[msp_pkg::START_W-1:0];
			len_q   <= info.match_len;
			last_q  <= eot_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, len_q, start_q};
	assign m_tlast  = last_q;

endmodule
`default_nettype wire

FILE: bench/tb_misspelled_word_spotter.sv
// Self-checking testbench for the whole-word misspelling spotter.
`timescale 1ns / 1ps
`default_nettype none
module tb_misspelled_word_spotter;

	localparam int MAX_LEN      = msp_pkg::DEF_MAX_PATTERN_LEN;
	localparam int HOLD_CYCLES  = 300;
	localparam int STALL_LIMIT  = 5000;
	localparam int SETTLE       = 8;
	localparam int SHOWN_ERRORS = 10;

	typedef struct packed {
		logic [msp_pkg::START_W-1:0]  start;
		logic [msp_pkg::LENGTH_W-1:0] length;
		logic                         last;
	} report_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;

	misspelled_word_spotter uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // [15:0] char_code
		.s_tlast   (s_tlast),   // end_of_text
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),   // [30:0] range_start, [34:31] range_length
		.m_tlast   (m_tlast),   // last_of_text
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)   // report_limit
	);

	string spell_list [msp_pkg::ROM_SIZE] = '{
		"acheive", "adress", "arguement", "becuase", "definately", "embarass",
		"goverment", "independant", "occured", "recieve", "seperate", "teh",
		"thier", "untill", "wierd"
	};

	// spotter state as the bench sees it
	logic [msp_pkg::COUNT_W-1:0]  report_limit = msp_pkg::REPORT_LIMIT_RESET;
	logic [msp_pkg::POS_W-1:0]    text_pos = '0;
	logic [msp_pkg::POS_W-1:0]    word_begin = '0;
	logic [3:0]                   word_letters = '0;
	logic [msp_pkg::ROM_SIZE-1:0] alive_mask = '1;
	logic [msp_pkg::COUNT_W-1:0]  reports_made = '0;
	logic                         in_word = 1'b0;

	report_t     pending_reports [$];
	logic [15:0] text_units [$];
	report_t     head;

	int mismatches = 0;
	int units_sent = 0;
	int texts_sent = 0;
	int reports_seen = 0;
	int limits_used = 0;
	int send_gap_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;
	bit hold_req = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic bit is_letter(logic [15:0] c);
		return (c >= 16'h0041 && c <= 16'h005A) || (c >= 16'h0061 && c <= 16'h007A);
	endfunction

	// Advance the predicted state by one code unit; queue a report if one is due.
	function automatic void spot_unit(logic [15:0] code, logic eot);
		logic [7:0] folded;
		bit         letter;
		bit         hit;
		letter = is_letter(code);
		hit = 1'b0;
		if (letter) begin
			folded = (code <= 16'h005A) ? code[7:0] + 8'd32 : code[7:0];
			if (!in_word) begin
				in_word = 1'b1;
				word_begin = text_pos;
				word_letters = '0;
				alive_mask = '1;
			end
			for (int p = 0; p < msp_pkg::ROM_SIZE; p++) begin
				if (!(word_letters < spell_list[p].len() &&
						spell_list[p][word_letters] == folded))
					alive_mask[p] = 1'b0;
			end
			if (word_letters < MAX_LEN + 1)
				word_letters++;
		end
		if (in_word && (!letter || eot)) begin
			if (word_letters != 0 && word_letters <= MAX_LEN) begin
				for (int p = 0; p < msp_pkg::ROM_SIZE; p++)
					if (alive_mask[p] && spell_list[p].len() == word_letters)
						hit = 1'b1;
			end
			if (hit && word_begin <= 32'h7FFF_FFFF && reports_made < report_limit) begin
				pending_reports.push_back('{word_begin[msp_pkg::START_W-1:0],
					word_letters, eot});
				reports_made++;
			end
			in_word = 1'b0;
			word_letters = '0;
			alive_mask = '1;
		end
		if (text_pos != '1)
			text_pos++;
		if (eot) begin
			text_pos = '0;
			word_begin = '0;
			reports_made = '0;
			in_word = 1'b0;
			word_letters = '0;
			alive_mask = '1;
		end
	endfunction

	task automatic log_mismatch(string what);
		mismatches++;
		if (mismatches <= SHOWN_ERRORS)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	// Result side: compare every accepted report with the oldest expected one.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			reports_seen++;
			if (pending_reports.size() == 0) begin
				log_mismatch($sformatf("unexpected report start=%0d length=%0d last=%0b",
					m_tdata[30:0], m_tdata[34:31], m_tlast));
			end else begin
				head = pending_reports.pop_front();
				if (m_tdata[30:0] !== head.start)
					log_mismatch($sformatf("range_start expected %0d got %0d",
						head.start, m_tdata[30:0]));
				if (m_tdata[34:31] !== head.length)
					log_mismatch($sformatf("range_length expected %0d got %0d",
						head.length, m_tdata[34:31]));
				if (m_tdata[39:35] !== 5'd0)
					log_mismatch($sformatf("tdata padding expected 0 got %0h",
						m_tdata[39:35]));
				if (m_tlast !== head.last)
					log_mismatch($sformatf("last_of_text expected %0b got %0b",
						head.last, m_tlast));
			end
		end
	end

	// Receiver: random stalls, or one long hold-off on request.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				m_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("[%0t] timeout: no item moved for %0d cycles", $time, quiet_cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic send_unit(logic [15:0] code, logic eot);
		s_tdata <= code;
		s_tlast <= eot;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		spot_unit(code, eot);
		units_sent++;
		if (eot)
			texts_sent++;
		if ($urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
		end
	endtask

	task automatic send_chars(string s, bit eot_on_last);
		for (int i = 0; i < s.len(); i++)
			send_unit({8'h00, s[i]}, eot_on_last && i == s.len() - 1);
	endtask

	// Sender pause until the report store is empty, then let the pipeline settle.
	task automatic quiesce();
		s_tvalid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_limit(logic [15:0] value);
		quiesce();
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		report_limit = value;
		limits_used++;
	endtask

	// Separators hug the letter ranges: 0x40, 0x5B, 0x60 and 0x7B among them.
	function automatic logic [15:0] pick_separator();
		string       marks;
		logic [15:0] c;
		marks = "@[{ .,";
		case ($urandom_range(5))
			0: c = 16'h0020;
			1: c = ($urandom_range(6) == 0) ? 16'h0060 :
				{8'h00, marks[$urandom_range(marks.len() - 1)]};
			2: c = 16'h0030 + 16'($urandom_range(9));
			3: c = 16'($urandom_range(16'h0080, 16'hFFFF));
			4: c = $urandom_range(1) ? 16'h0000 : 16'hFFFF;
			default: begin
				do c = 16'($urandom_range(16'hFFFF)); while (is_letter(c));
			end
		endcase
		return c;
	endfunction

	function automatic void push_letter(logic [7:0] lower_ch);
		text_units.push_back({8'h00, $urandom_range(1) ? lower_ch - 8'd32 : lower_ch});
	endfunction

	// One token: half the time an exact misspelling in mixed case, else a near miss or random letters.
	function automatic void push_word();
		string w;
		int    kind;
		int    n;
		int    pos;
		logic [7:0] ch;
		w = spell_list[$urandom_range(msp_pkg::ROM_SIZE - 1)];
		kind = $urandom_range(9);
		n = w.len();
		pos = $urandom_range(n - 1);
		if (kind == 8) begin
			repeat ($urandom_range(1, 15)) push_letter(8'h61 + 8'($urandom_range(25)));
			return;
		end
		if (kind == 6)
			n = n - 1;
		repeat ((kind == 9) ? 2 : 1) begin
			for (int i = 0; i < n; i++) begin
				ch = w[i];
				if (kind == 5 && i == pos)
					ch = 8'h61 + 8'($urandom_range(25));
				push_letter(ch);
			end
		end
		if (kind == 7)
			push_letter(8'h61 + 8'($urandom_range(25)));
	endfunction

	function automatic void compose_text();
		text_units.delete();
		if ($urandom_range(9) == 0) begin
			repeat ($urandom_range(1, 30)) text_units.push_back(16'($urandom_range(16'hFFFF)));
			return;
		end
		if ($urandom_range(3) == 0)
			text_units.push_back(pick_separator());
		repeat ($urandom_range(1, 12)) begin
			push_word();
			repeat ($urandom_range(1, 2)) text_units.push_back(pick_separator());
		end
		// half of the word texts end on a letter so the final letter closes the token
		if ($urandom_range(1)) begin
			while (text_units.size() > 1 && !is_letter(text_units[$]))
				void'(text_units.pop_back());
		end
	endfunction

	task automatic run_texts(int target);
		int first;
		first = units_sent;
		while (units_sent - first < target) begin
			compose_text();
			foreach (text_units[i])
				send_unit(text_units[i], i == text_units.size() - 1);
		end
	endtask

	task automatic test_directed();
		send_unit(16'h0000, 1'b0);
		send_chars("tEh", 1'b0);
		send_unit(16'hFFFF, 1'b1);
		send_chars("TEH", 1'b1);
		send_chars("z@WieRd[A", 1'b0);
		send_unit(16'h0060, 1'b0);
		send_chars("a{", 1'b0);
		send_unit(16'h00E9, 1'b1);
	endtask

	task automatic test_free_flow();
		send_gap_pct = 0;
		stall_pct = 0;
		run_texts(300);
	endtask

	task automatic test_zero_limit();
		set_limit(16'd0);
		run_texts(100);
	endtask

	task automatic test_small_limits();
		set_limit(16'd1);
		run_texts(100);
		set_limit(16'd3);
		run_texts(100);
	endtask

	task automatic test_sender_gaps();
		set_limit(16'hFFFF);
		send_gap_pct = 63;
		stall_pct = 0;
		run_texts(300);
	endtask

	task automatic test_receiver_stalls();
		send_gap_pct = 0;
		stall_pct = 63;
		run_texts(300);
	endtask

	task automatic test_both_idle();
		set_limit(16'd5);
		send_gap_pct = 7;
		stall_pct = 7;
		run_texts(200);
	endtask

	// Receiver holds off while the sender keeps pushing dense matches.
	task automatic test_backpressure();
		set_limit(16'hFFFF);
		send_gap_pct = 0;
		stall_pct = 0;
		hold_req = 1'b1;
		for (int i = 0; i < 100; i++) begin
			send_chars("teh", 1'b0);
			send_unit(16'h0020, i == 99);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_free_flow();
		test_zero_limit();
		test_small_limits();
		test_sender_gaps();
		test_receiver_stalls();
		test_both_idle();
		test_backpressure();
		quiesce();
		repeat (SETTLE) @(posedge clk);
		if (pending_reports.size() != 0)
			log_mismatch($sformatf("%0d expected reports never came", pending_reports.size()));
		$display("Sent %0d code units in %0d texts, checked %0d match reports.",
			units_sent, texts_sent, reports_seen);
		$display("Covered %0d report limit writes, sender gaps, receiver stalls and a long hold-off.",
			limits_used);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
`default_nettype wire

FILE: files.f
sv/msp_pkg.sv
sv/msp_classify.sv
sv/msp_pattern_unit.sv
sv/misspelled_word_spotter.sv
bench/tb_misspelled_word_spotter.sv
